// ----- rtl/tsts_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and default sizes of the tagged stack
package tsts_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int TYPE_COUNT_DEF  = 16;
    localparam int TOKEN_BITS_DEF  = 16;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  found_type;
        logic [15:0] found_token;
        logic [4:0]  found_position;
        logic [5:0]  fill_level;
    } t_result;

endpackage

// ----- rtl/tagged_stack_with_type_search_core.sv -----
`timescale 1ns / 1ps
// top level of the tagged stack with search by type set
//
// input channel: i_in_valid / o_in_stall carry one operation word (opcode,
// label type, token reference, type mask). output channel: o_out_valid /
// i_out_stall carry one result word per operation (status, found type,
// token, position, fill level). a word moves when valid is high and stall
// is low.
// entries live in a single-port-read, single-port-write memory with
// registered read data; operations run one at a time.
// a push writes its entry; pop and peek read the top entry; search reads
// entries from the top until one matches or the bottom is reached, each
// entry check costing one memory read. pop, peek or search on an empty
// stack reads nothing. the result shows on o_out_valid in the same cycle
// as the next word can be taken.
// the output register lets the next word be taken while a result waits.
// reset empties the stack and drops any pending result; entry contents are
// not cleared. while i_out_stall is high the result holds, one more
// operation can finish behind it, then o_in_stall stays high until the
// output moves.
module tagged_stack_with_type_search_core #(
    parameter int STACK_DEPTH = tsts_pkg::STACK_DEPTH_DEF,
    parameter int TYPE_COUNT  = tsts_pkg::TYPE_COUNT_DEF,
    parameter int TOKEN_BITS  = tsts_pkg::TOKEN_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_label_type,
    input  logic [15:0] i_token_ref,
    input  logic [15:0] i_type_mask,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_found_type,
    output logic [15:0] o_found_token,
    output logic [4:0]  o_found_position,
    output logic [5:0]  o_fill_level
);
    import tsts_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = 4 + TOKEN_BITS;

    t_result       res;
    logic          res_valid;
    logic          res_take;
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [DW-1:0] rdata;

    logic          r_out_valid;
    t_result       r_out;

    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    tsts_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .TYPE_COUNT  (TYPE_COUNT),
        .TOKEN_BITS  (TOKEN_BITS),
        .AW          (AW),
        .CW          (CW),
        .DW          (DW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_label_type (i_label_type),
        .i_token_ref  (i_token_ref),
        .i_type_mask  (i_type_mask),
        .o_res        (res),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    tsts_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_type     = r_out.found_type;
    assign o_found_token    = r_out.found_token;
    assign o_found_position = r_out.found_position;
    assign o_fill_level     = r_out.fill_level;

endmodule

// ----- rtl/tsts_mem.sv -----
`timescale 1ns / 1ps
// entry memory: one write port, one read port with registered read data
module tsts_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 20
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tsts_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer: decodes each word, drives the entry memory and builds the result
module tsts_ctrl #(
    parameter int STACK_DEPTH = 32,
    parameter int TYPE_COUNT  = 16,
    parameter int TOKEN_BITS  = 16,
    parameter int AW          = 5,
    parameter int CW          = 6,
    parameter int DW          = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_opcode,
    input  logic [3:0]            i_label_type,
    input  logic [15:0]           i_token_ref,
    input  logic [15:0]           i_type_mask,
    output tsts_pkg::t_result     o_res,
    output logic                  o_res_valid,
    input  logic                  i_res_take,
    output logic                  o_we,
    output logic [AW-1:0]         o_waddr,
    output logic [DW-1:0]         o_wdata,
    output logic                  o_re,
    output logic [AW-1:0]         o_raddr,
    input  logic [DW-1:0]         i_rdata
);
    import tsts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [15:0]     r_mask, n_mask;
    t_result         r_res, n_res;

    logic                  accept;
    logic [63:0]           tok_in_ext;
    logic [TOKEN_BITS-1:0] tok_in;
    logic [3:0]            rd_type;
    logic [63:0]           rd_tok_ext;
    logic [15:0]           rd_tok;
    logic                  rd_hit;
    logic [AW-1:0]         top_addr;
    t_result               hit_res;
    t_result               miss_res;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_res      = r_res;
    assign o_res_valid = (r_state == S_DONE);

    assign tok_in_ext = 64'(i_token_ref);
    assign tok_in     = tok_in_ext[TOKEN_BITS-1:0];
    assign rd_type    = i_rdata[DW-1 -: 4];
    assign rd_tok_ext = 64'(i_rdata[TOKEN_BITS-1:0]);
    assign rd_tok     = rd_tok_ext[15:0];
    // types at or above the type count never match
    assign rd_hit     = (32'(rd_type) < TYPE_COUNT) && r_mask[rd_type];
    assign top_addr   = AW'(r_count - CW'(1));

    always_comb begin
        hit_res                = '0;
        hit_res.status         = ST_OK;
        hit_res.found_type     = rd_type;
        hit_res.found_token    = rd_tok;
        hit_res.found_position = 5'(r_ptr);
        hit_res.fill_level     = 6'(r_count);
        miss_res               = '0;
        miss_res.status        = ST_EMPTY;
        miss_res.fill_level    = 6'(r_count);
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_mask  = r_mask;
        n_res   = r_res;
        o_we    = 1'b0;
        o_waddr = AW'(r_count);
        o_wdata = {i_label_type, tok_in};
        o_re    = 1'b0;
        o_raddr = top_addr;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res   = miss_res;
                    n_state = S_DONE;
                    case (i_opcode)
                        OP_PUSH: begin
                            if (r_count < CW'(STACK_DEPTH)) begin
                                o_we             = 1'b1;
                                n_count          = r_count + CW'(1);
                                n_res.status     = ST_OK;
                                n_res.fill_level = 6'(r_count + CW'(1));
                            end else begin
                                n_res.status = ST_OVERFLOW;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (r_count != '0) begin
                                o_re    = 1'b1;
                                n_ptr   = top_addr;
                                n_state = S_READ;
                                if (i_opcode == OP_POP) begin
                                    n_count = r_count - CW'(1);
                                end
                            end
                        end
                        default: begin
                            n_mask = i_type_mask;
                            if (r_count != '0) begin
                                o_re    = 1'b1;
                                n_ptr   = top_addr;
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res   = hit_res;
                n_state = S_DONE;
            end
            S_SCAN: begin
                // one entry per cycle, next read issued while this one is checked
                if (rd_hit) begin
                    n_res   = hit_res;
                    n_state = S_DONE;
                end else if (r_ptr == '0) begin
                    n_res   = miss_res;
                    n_state = S_DONE;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = r_ptr - AW'(1);
                    n_ptr   = r_ptr - AW'(1);
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_ptr  <= n_ptr;
        r_mask <= n_mask;
        r_res  <= n_res;
    end

endmodule

// ----- rtl/tsts_chk.sv -----
`timescale 1ns / 1ps
// port checker for the tagged stack, bound to the top level
module tsts_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [3:0]  o_found_type,
    input logic [15:0] o_found_token,
    input logic [4:0]  o_found_position,
    input logic [5:0]  o_fill_level
);
    import tsts_pkg::*;

    // a stalled result word stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_status) && $stable(o_found_token)
            && $stable(o_fill_level))
        else $error("result word changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // no entry is returned with an overflow or empty status (empty also marks a search that finds nothing)
    a_no_entry_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OVERFLOW || o_status == ST_EMPTY)
            |-> o_found_type == '0 && o_found_token == '0 && o_found_position == '0)
        else $error("entry fields set on a failed operation");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OVERFLOW |-> o_fill_level != '0)
        else $error("overflow reported on an empty stack");

endmodule

bind tagged_stack_with_type_search_core tsts_chk u_tsts_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_found_type     (o_found_type),
    .o_found_token    (o_found_token),
    .o_found_position (o_found_position),
    .o_fill_level     (o_fill_level)
);
